>>> rtl/probe_period_to_thickness_top_macros.svh
// Assertion macros for the probe period to thickness block
`ifndef PROBE_PERIOD_TO_THICKNESS_TOP_MACROS_SVH
`define PROBE_PERIOD_TO_THICKNESS_TOP_MACROS_SVH

// consequent in the same cycle
`define PPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the next cycle
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppt_pkg.sv
// Package: types, constants and saturation helpers for the probe period to thickness block
package ppt_pkg;

    localparam int TICK_RATE_DEF = 1000000;
    localparam int TABLE_DEPTH   = 32;
    localparam int IDX_W         = 5;
    localparam int FREQ_W        = 24;
    localparam int WORD_W        = 48;
    localparam int NUM_W         = 48;
    localparam int DEN_W         = 32;
    localparam int CFG_IDX_W     = 3;

    localparam logic [FREQ_W-1:0] Q16_ONE = 24'd65536;
    localparam logic [FREQ_W-1:0] LIM75   = 24'(75 * 65536);

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_INF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_INF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_UP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd5;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         table_index;
        logic signed [WORD_W-1:0] table_value;
        logic [31:0]              period_count;
    } t_in_item;

    typedef struct packed {
        logic               thickness_valid;
        logic signed [31:0] thickness;
        logic [FREQ_W-1:0]  scaled_freq;
    } t_out_item;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_7FFF_FFFF_FFFF;
        lo = -hi - 50'sd1;
        if (v > hi) return 48'sh7FFF_FFFF_FFFF;
        if (v < lo) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // magnitude of a signed word; 2^47 still fits unsigned
    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

endpackage

>>> rtl/probe_period_to_thickness_top.sv
// Top level: probe period to coating thickness converter
//
// Usage: pulse start with an item on i_item while busy is low. A load item
// (kind 0) writes one coefficient word and gives a zero result word on the
// next cycle; the block stays free. A measure item (kind 1) raises busy and
// runs a bit-serial divider for the frequency, one multiply, a second
// division for the normalisation, the set-up states CHECK, CTR and TOP,
// then Horner steps of PREP, MUL and ADD (3 steps for the top segment,
// else 6); one item at a time. The single shared 24x24 multiplier
// is used four times per Horner product and once for the frequency.
// Each result word sits on o_result for one cycle with o_done high; the
// receiver cannot hold it off. Config writes (i_cfg_we) are taken at any
// edge and belong in idle time. Reset restores the register defaults and
// idles the sequencer; the coefficient table is not cleared and must be
// loaded before measuring.
`include "probe_period_to_thickness_top_macros.svh"

module probe_period_to_thickness_top #(
    parameter int TICK_RATE = ppt_pkg::TICK_RATE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  ppt_pkg::t_in_item                i_item,
    output logic                             busy,
    input  logic                             i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [ppt_pkg::FREQ_W-1:0]       i_cfg_wdata,
    output logic                             o_done,
    output ppt_pkg::t_out_item               o_result
);
    import ppt_pkg::*;

    localparam logic [NUM_W-1:0] NUMER = NUM_W'(TICK_RATE) << 16;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DIV1  = 10'b00_0000_0010,
        ST_MULF  = 10'b00_0000_0100,
        ST_DIV2  = 10'b00_0000_1000,
        ST_CHECK = 10'b00_0001_0000,
        ST_CTR   = 10'b00_0010_0000,
        ST_TOP   = 10'b00_0100_0000,
        ST_PREP  = 10'b00_1000_0000,
        ST_MUL   = 10'b01_0000_0000,
        ST_ADD   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [FREQ_W-1:0] r_ref, r_meas, r_seg_up, r_seg_mid, r_seg_low, r_end;

    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [5:0]        r_cnt, n_cnt;
    logic [FREQ_W-1:0] r_f, n_f;
    logic [FREQ_W-1:0] r_scaled, n_scaled;
    logic [1:0]        r_seg, n_seg;
    logic [2:0]        r_k, n_k;
    logic signed [47:0] r_d, n_d;
    logic signed [47:0] r_acc, n_acc;
    logic [47:0]       r_amag, n_amag;
    logic [47:0]       r_dmag, n_dmag;
    logic              r_neg, n_neg;
    logic [95:0]       r_prod, n_prod;
    logic              r_done, n_done;
    t_out_item         r_res, n_res;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic signed [WORD_W-1:0] r_rd;
    logic [IDX_W-1:0]  rd_addr;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // restoring divider step
    logic [DEN_W:0]   rem_sh, rem_nx;
    logic             q_bit;
    logic [NUM_W-1:0] num_nx;
    logic [FREQ_W-1:0] quot_sat;
    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_den});
    assign rem_nx   = q_bit ? rem_sh - {1'b0, r_den} : rem_sh;
    assign num_nx   = {r_num[NUM_W-2:0], q_bit};
    assign quot_sat = (|num_nx[NUM_W-1:FREQ_W]) ? '1 : num_nx[FREQ_W-1:0];

    // shared 24x24 multiplier
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;
    logic [95:0] pp;
    always_comb begin
        mul_a = r_f;
        mul_b = r_ref;
        if (r_state == ST_MUL) begin
            unique case (r_cnt[1:0])
                2'd0: begin
                    mul_a = r_amag[23:0];
                    mul_b = r_dmag[23:0];
                end
                2'd1: begin
                    mul_a = r_amag[23:0];
                    mul_b = r_dmag[47:24];
                end
                2'd2: begin
                    mul_a = r_amag[47:24];
                    mul_b = r_dmag[23:0];
                end
                default: begin
                    mul_a = r_amag[47:24];
                    mul_b = r_dmag[47:24];
                end
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    pp = {48'd0, mul_p};
            2'd1,
            2'd2:    pp = {24'd0, mul_p, 24'd0};
            default: pp = {mul_p, 48'd0};
        endcase
    end

    // normalisation divisor
    logic [FREQ_W-1:0] dv;
    always_comb begin
        if (r_meas < LIM75) begin
            dv = (r_end > Q16_ONE) ? r_end - Q16_ONE : '0;
        end else begin
            dv = r_meas;
        end
    end

    // segment choice
    logic [1:0] seg_c;
    logic       meas_ok;
    assign meas_ok = (r_scaled > LIM75) && (r_scaled > r_end);
    always_comb begin
        priority if (r_scaled > r_seg_up) begin
            seg_c = 2'd0;
        end else if (r_scaled > r_seg_mid) begin
            seg_c = 2'd1;
        end else if (r_scaled > r_seg_low) begin
            seg_c = 2'd2;
        end else begin
            seg_c = 2'd3;
        end
    end

    // product scaling and Horner add
    logic [47:0]        m48, lim, mv;
    logic signed [48:0] msig;
    logic signed [49:0] hsum;
    logic signed [47:0] acc_nx;
    logic signed [49:0] dsum;
    assign m48  = r_prod[63:16];
    assign lim  = r_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    assign mv   = ((|r_prod[95:64]) || (m48 > lim)) ? lim : m48;
    assign msig = r_neg ? -$signed({1'b0, mv}) : $signed({1'b0, mv});
    assign hsum = 50'(msig) + 50'(r_rd);
    assign acc_nx = sat48(hsum);
    assign dsum = $signed({26'd0, r_scaled}) - 50'(r_rd);

    always_comb begin
        unique case (r_state)
            ST_CHECK: rd_addr = {seg_c, 3'd0};
            ST_CTR:   rd_addr = {r_seg, r_k + 3'd1};
            default:  rd_addr = {r_seg, r_k};
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_num    = r_num;
        n_rem    = r_rem;
        n_den    = r_den;
        n_cnt    = r_cnt;
        n_f      = r_f;
        n_scaled = r_scaled;
        n_seg    = r_seg;
        n_k      = r_k;
        n_d      = r_d;
        n_acc    = r_acc;
        n_amag   = r_amag;
        n_dmag   = r_dmag;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_done   = 1'b0;
        n_res    = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.kind == KIND_LOAD) begin
                        n_res  = '0;
                        n_done = 1'b1;
                    end else if (i_item.period_count == '0) begin
                        n_f     = '0;
                        n_state = ST_MULF;
                    end else begin
                        n_num   = NUMER;
                        n_rem   = '0;
                        n_den   = i_item.period_count;
                        n_cnt   = '0;
                        n_state = ST_DIV1;
                    end
                end
            end
            ST_DIV1, ST_DIV2: begin
                n_num = num_nx;
                n_rem = rem_nx[DEN_W-1:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(NUM_W - 1)) begin
                    if (r_state == ST_DIV1) begin
                        n_f     = quot_sat;
                        n_state = ST_MULF;
                    end else begin
                        n_scaled = quot_sat;
                        n_state  = ST_CHECK;
                    end
                end
            end
            ST_MULF: begin
                if (dv == '0) begin
                    n_scaled = '0;
                    n_state  = ST_CHECK;
                end else begin
                    n_num   = mul_p;
                    n_rem   = '0;
                    n_den   = DEN_W'(dv);
                    n_cnt   = '0;
                    n_state = ST_DIV2;
                end
            end
            ST_CHECK: begin
                if (meas_ok) begin
                    n_seg   = seg_c;
                    n_k     = (seg_c == 2'd0) ? 3'd3 : 3'd6;
                    n_state = ST_CTR;
                end else begin
                    n_res   = '{thickness_valid: 1'b0, thickness: '0, scaled_freq: r_scaled};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CTR: begin
                n_d     = sat48(dsum);
                n_state = ST_TOP;
            end
            ST_TOP: begin
                n_acc   = r_rd;
                n_dmag  = mag48(r_d);
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_amag  = mag48(r_acc);
                n_neg   = r_acc[47] ^ r_d[47];
                n_prod  = '0;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod = r_prod + pp;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_acc = acc_nx;
                if (r_k == 3'd1) begin
                    n_res   = '{thickness_valid: 1'b1, thickness: sat32(acc_nx),
                                scaled_freq: r_scaled};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_k     = r_k - 3'd1;
                    n_state = ST_PREP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_done    <= 1'b0;
            r_ref     <= 24'd5122862;
            r_meas    <= 24'd0;
            r_seg_up  <= 24'd7170051;
            r_seg_mid <= 24'd5773125;
            r_seg_low <= 24'd5587710;
            r_end     <= 24'd5305421;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_REF_INF:  r_ref     <= i_cfg_wdata;
                    CFG_MEAS_INF: r_meas    <= i_cfg_wdata;
                    CFG_SEG_UP:   r_seg_up  <= i_cfg_wdata;
                    CFG_SEG_MID:  r_seg_mid <= i_cfg_wdata;
                    CFG_SEG_LOW:  r_seg_low <= i_cfg_wdata;
                    CFG_END:      r_end     <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_cnt    <= n_cnt;
        r_f      <= n_f;
        r_scaled <= n_scaled;
        r_seg    <= n_seg;
        r_k      <= n_k;
        r_d      <= n_d;
        r_acc    <= n_acc;
        r_amag   <= n_amag;
        r_dmag   <= n_dmag;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_res    <= n_res;
    end

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (accept && i_item.kind == KIND_LOAD) begin
            mem[i_item.table_index] <= i_item.table_value;
        end
        r_rd <= mem[rd_addr];
    end

    `PPT_ASSERT_NEXT(a_measure_busy, i_clk, i_rst_n,
        start && !busy && i_item.kind == KIND_MEASURE, busy, "measure item did not raise busy")
    `PPT_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n,
        r_state == ST_DIV1 || r_state == ST_DIV2, r_den != '0, "divider running on zero")
    `PPT_ASSERT_NOW(a_add_after_mul, i_clk, i_rst_n,
        r_state == ST_ADD, $past(r_state) == ST_MUL, "Horner add without a product")
    `PPT_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n,
        o_done && !o_result.thickness_valid, o_result.thickness == '0,
        "invalid word carries a thickness")

endmodule
